// ===== rtl/swrl_pkg.sv =====
// ----------------------------------------------------------------------------
// swrl_pkg
// Shared widths, constants, register codes and channel payload types of the
// sliding window rate limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package swrl_pkg;

  // Default width of the per-window request counters.
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Field widths.
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned MS_W       = 10;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned PERIOD_W   = 24;
  localparam int unsigned EST_W      = 17;
  localparam int unsigned ACT_W      = 42;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 24;

  // Milliseconds per second and the largest legal millisecond value.
  localparam int unsigned MS_PER_S = 1000;
  localparam int unsigned MS_LAST  = 999;

  // floor(y / 1000) equals (y * RECIP_1000) >> RECIP_SHIFT for y below 10^6.
  localparam int unsigned RECIP_1000  = 1073742;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam int unsigned RECIP_W     = 21;
  localparam int unsigned SMALL_W     = 20;

  // The division remainder is below 2000, so 11 bits hold it exactly.
  localparam int unsigned RESID_W = 11;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_PER_SECOND   = 1'b0,
    CFG_HEARTBEAT_PERIOD = 1'b1
  } cfg_reg_e;

  // Item modes.
  localparam logic MODE_REQUEST   = 1'b0;
  localparam logic MODE_HEARTBEAT = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [TIME_W-1:0] time_s;
    logic [MS_W-1:0]   ms_in_second;
  } req_t;

  typedef struct packed {
    logic             granted;
    logic [EST_W-1:0] window_estimate;
  } rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

`default_nettype wire

// ===== rtl/swrl_chan_if.sv =====
// ----------------------------------------------------------------------------
// swrl_chan_if
// Valid/ready channel carrying one payload of a chosen type.
// ----------------------------------------------------------------------------
`default_nettype none

interface swrl_chan_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ===== rtl/sliding_window_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter
// Sliding-window-counter rate limiter with a heartbeat, pipelined so that one
// request can enter in every cycle while rsp_o takes responses.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Payload    Meaning
//   cfg_i    in   cfg_wr_t   register write, always ready
//   req_i    in   req_t      timestamped request or heartbeat query
//   rsp_o    out  rsp_t      one grant decision and estimate per request
//
// The response of a request passes through stages a, b, c and d and the
// response register onto rsp_o, and one request per cycle is sustained
// while rsp_o takes each response. Three stages ahead of the commit stage
// build the scaled window weight and the products of the previous count,
// and the response register follows the commit stage. The commit stage
// reads and writes the window counters in the same cycle, and the stage
// before it forwards the commit outcome so that neighbors need no gap.
// Reset clears the configuration, the window state and the last activity
// time at once; there is no clearing pass.
// Each stage moves on when the stage after it is empty or moving, so a
// waiting response blocks req_i only when every stage holds a request.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_rate_limiter #(
  parameter int unsigned COUNT_BITS = swrl_pkg::COUNT_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  swrl_chan_if.sink     cfg_i,
  swrl_chan_if.sink     req_i,
  swrl_chan_if.source   rsp_o
);

  // Local copies of the package widths, usable as cast sizes.
  localparam int unsigned TimeW   = swrl_pkg::TIME_W;
  localparam int unsigned MsW     = swrl_pkg::MS_W;
  localparam int unsigned LimitW  = swrl_pkg::LIMIT_W;
  localparam int unsigned PeriodW = swrl_pkg::PERIOD_W;
  localparam int unsigned EstW    = swrl_pkg::EST_W;
  localparam int unsigned ActW    = swrl_pkg::ACT_W;
  localparam int unsigned SmallW  = swrl_pkg::SMALL_W;
  localparam int unsigned RecipW  = swrl_pkg::RECIP_W;
  localparam int unsigned ResidW  = swrl_pkg::RESID_W;
  localparam int unsigned MsPerS  = swrl_pkg::MS_PER_S;

  // The quotient floor(P*w/1000) is approximated as (P*c) >> COUNT_BITS with
  // c = floor(w * 2^COUNT_BITS / 1000). Since P < 2^COUNT_BITS the estimate
  // is low by at most one, which the remainder test corrects.
  // c is split as w*ScaleF + floor(w*ScaleRem/1000).
  localparam longint unsigned Pow2K    = 64'd1 << COUNT_BITS;
  localparam longint unsigned ScaleF   = Pow2K / MsPerS;
  localparam longint unsigned ScaleRem = Pow2K % MsPerS;
  localparam int unsigned     CW       = COUNT_BITS + 1;
  localparam int unsigned     WfW      = CW + MsW;
  localparam int unsigned     RqW      = SmallW + RecipW;
  localparam int unsigned     PcW      = 2 * COUNT_BITS + 1;
  localparam int unsigned     PwW      = COUNT_BITS + MsW;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes must arrive only while the block is idle; the block itself does not enforce it.
  // --------------------------------------------------------------------------
  logic [LimitW-1:0]  max_per_second_q;
  logic [PeriodW-1:0] hb_period_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_per_second_q <= '0;
      hb_period_q      <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (swrl_pkg::cfg_reg_e'(cfg_i.payload.index))
        swrl_pkg::CFG_MAX_PER_SECOND: begin
          max_per_second_q <= cfg_i.payload.data[LimitW-1:0];
        end
        swrl_pkg::CFG_HEARTBEAT_PERIOD: begin
          hb_period_q <= cfg_i.payload.data[PeriodW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Window state and pipeline registers.
  // --------------------------------------------------------------------------
  logic [TimeW-1:0]      window_second_q;
  logic [COUNT_BITS-1:0] current_count_q;
  logic [COUNT_BITS-1:0] previous_count_q;
  logic [ActW-1:0]       last_activity_q;

  // Stage a: captured request, milliseconds clamped, window weight.
  logic              a_v_q;
  logic              a_mode_q;
  logic [TimeW-1:0]  a_time_q;
  logic [MsW-1:0]    a_ms_q;
  logic [MsW-1:0]    a_w_q;

  // Stage b: absolute time and the two parts of the scaled weight.
  logic              b_v_q;
  logic              b_mode_q;
  logic [TimeW-1:0]  b_time_q;
  logic [MsW-1:0]    b_w_q;
  logic [ActW-1:0]   b_now_q;
  logic [SmallW-1:0] b_wr_q;
  logic [CW-1:0]     b_wf_q;

  // Stage c: finished scaled weight.
  logic              c_v_q;
  logic              c_mode_q;
  logic [TimeW-1:0]  c_time_q;
  logic [MsW-1:0]    c_w_q;
  logic [ActW-1:0]   c_now_q;
  logic [CW-1:0]     c_c_q;

  // Stage d: products of the previous count, ready for commit.
  logic              d_v_q;
  logic              d_mode_q;
  logic [TimeW-1:0]  d_time_q;
  logic [MsW-1:0]    d_w_q;
  logic [ActW-1:0]   d_now_q;
  logic [CW-1:0]     d_c_q;
  logic [PcW-1:0]    d_pc_q;
  logic [ResidW-1:0] d_pwl_q;
  logic              d_inc_q;
  logic              d_gprev_q;

  // Response register.
  logic              rsp_v_q;
  logic              rsp_granted_q;
  logic [EstW-1:0]   rsp_est_q;

  // --------------------------------------------------------------------------
  // Flow control: a stage moves when the next one is empty or moving.
  // --------------------------------------------------------------------------
  logic rsp_free, d_mv, d_acc, c_mv, c_acc, b_mv, b_acc, a_mv, a_acc, in_fire;

  assign rsp_free = !rsp_v_q || rsp_o.ready;
  assign d_mv     = d_v_q && rsp_free;
  assign d_acc    = !d_v_q || d_mv;
  assign c_mv     = c_v_q && d_acc;
  assign c_acc    = !c_v_q || c_mv;
  assign b_mv     = b_v_q && c_acc;
  assign b_acc    = !b_v_q || b_mv;
  assign a_mv     = a_v_q && b_acc;
  assign a_acc    = !a_v_q || a_mv;

  assign req_i.ready = a_acc;
  assign in_fire     = req_i.valid && a_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      c_v_q   <= 1'b0;
      d_v_q   <= 1'b0;
      rsp_v_q <= 1'b0;
    end else begin
      a_v_q   <= (a_v_q && !a_mv) || in_fire;
      b_v_q   <= (b_v_q && !b_mv) || a_mv;
      c_v_q   <= (c_v_q && !c_mv) || b_mv;
      d_v_q   <= (d_v_q && !d_mv) || c_mv;
      rsp_v_q <= (rsp_v_q && !rsp_o.ready) || d_mv;
    end
  end

  // --------------------------------------------------------------------------
  // Stage a: clamp milliseconds to 999 and form the weight 1000 - ms.
  // --------------------------------------------------------------------------
  logic [MsW-1:0] in_ms_sat;

  assign in_ms_sat = (req_i.payload.ms_in_second > MsW'(swrl_pkg::MS_LAST)) ?
                     MsW'(swrl_pkg::MS_LAST) : req_i.payload.ms_in_second;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_mode_q <= req_i.payload.mode;
      a_time_q <= req_i.payload.time_s;
      a_ms_q   <= in_ms_sat;
      a_w_q    <= MsW'(MsPerS) - in_ms_sat;
    end
  end

  // --------------------------------------------------------------------------
  // Stage b: absolute millisecond time and the partial products of c.
  // --------------------------------------------------------------------------
  logic [ActW-1:0]   a_now;
  logic [SmallW-1:0] a_wr;
  logic [WfW-1:0]    a_wf_full;

  assign a_now     = ActW'(a_time_q) * ActW'(MsPerS) + ActW'(a_ms_q);
  assign a_wr      = SmallW'(a_w_q) * SmallW'(ScaleRem);
  assign a_wf_full = WfW'(a_w_q) * WfW'(ScaleF);

  always_ff @(posedge clk_i) begin
    if (a_mv) begin
      b_mode_q <= a_mode_q;
      b_time_q <= a_time_q;
      b_w_q    <= a_w_q;
      b_now_q  <= a_now;
      b_wr_q   <= a_wr;
      b_wf_q   <= CW'(a_wf_full);
    end
  end

  // --------------------------------------------------------------------------
  // Stage c: c = w*ScaleF + floor(w*ScaleRem / 1000) by reciprocal.
  // --------------------------------------------------------------------------
  logic [RqW-1:0] b_rq;
  logic [CW-1:0]  b_c;

  assign b_rq = RqW'(b_wr_q) * RqW'(swrl_pkg::RECIP_1000);
  assign b_c  = b_wf_q + CW'(b_rq >> swrl_pkg::RECIP_SHIFT);

  always_ff @(posedge clk_i) begin
    if (b_mv) begin
      c_mode_q <= b_mode_q;
      c_time_q <= b_time_q;
      c_w_q    <= b_w_q;
      c_now_q  <= b_now_q;
      c_c_q    <= b_c;
    end
  end

  // --------------------------------------------------------------------------
  // Commit stage (d). The window rolls, the estimate is formed and compared,
  // and the counters and activity time are written as the request leaves.
  // --------------------------------------------------------------------------
  logic                  d_active;
  logic                  d_roll;
  logic                  d_adj;
  logic [COUNT_BITS-1:0] prev_n;
  logic [COUNT_BITS-1:0] cur_n;
  logic                  bump;
  logic [ResidW-1:0]     x_low;
  logic [PcW-1:0]        pc_t;
  logic [EstW-1:0]       q0;
  logic [ResidW-1:0]     q0k;
  logic [ResidW-1:0]     resid;
  logic [EstW-1:0]       est;
  logic                  grant;
  logic                  req_commit;
  logic [ActW-1:0]       act_gap;
  logic                  hb_due;

  assign d_active = (d_mode_q == swrl_pkg::MODE_REQUEST) && (max_per_second_q != '0);
  assign d_roll   = d_time_q != window_second_q;
  assign d_adj    = window_second_q == TimeW'(d_time_q - TimeW'(1));

  // Adjacent windows carry the count forward; a gap clears it.
  assign prev_n = d_roll ? (d_adj ? current_count_q : '0) : previous_count_q;
  assign cur_n  = d_roll ? '0 : current_count_q;

  // The products in stage d were taken on the count seen before the request
  // ahead committed; when that request was granted into the count that
  // becomes this one's previous count, add one more weight.
  assign bump  = d_inc_q && d_gprev_q;
  assign x_low = d_pwl_q + (bump ? ResidW'(d_w_q) : '0);
  assign pc_t  = d_pc_q + (bump ? PcW'(d_c_q) : '0);

  // Quotient estimate, then one correction when the remainder reaches 1000.
  assign q0    = EstW'(pc_t >> COUNT_BITS);
  assign q0k   = ResidW'(q0[ResidW-1:0] * ResidW'(MsPerS));
  assign resid = x_low - q0k;
  assign est   = q0 + EstW'(resid >= ResidW'(MsPerS)) + EstW'(cur_n);
  assign grant = est < EstW'(max_per_second_q);

  assign req_commit = d_mv && d_active;

  // Heartbeat: due when enabled, time has not gone backward and the period
  // has elapsed since the last activity.
  assign act_gap = d_now_q - last_activity_q;
  assign hb_due  = (d_mode_q == swrl_pkg::MODE_HEARTBEAT) && (hb_period_q != '0) &&
                   (d_now_q >= last_activity_q) && (act_gap >= ActW'(hb_period_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_second_q  <= '0;
      current_count_q  <= '0;
      previous_count_q <= '0;
      last_activity_q  <= '0;
    end else if (d_mv) begin
      if (d_active) begin
        window_second_q  <= d_time_q;
        previous_count_q <= prev_n;
        if (grant && (cur_n != '1)) begin
          current_count_q <= cur_n + COUNT_BITS'(1);
        end else begin
          current_count_q <= cur_n;
        end
        if (grant) begin
          last_activity_q <= d_now_q;
        end
      end else if (hb_due) begin
        last_activity_q <= d_now_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Product stage (c to d). It works on the state as it will stand after the
  // request in stage d commits at the same edge. Only that request's grant is
  // unknown here, and it can only add one to the count being carried forward.
  // --------------------------------------------------------------------------
  logic [TimeW-1:0]      win_after;
  logic [COUNT_BITS-1:0] prev_after;
  logic [COUNT_BITS-1:0] cur_base_after;
  logic                  c_roll;
  logic                  c_adj;
  logic [COUNT_BITS-1:0] c_p;
  logic                  c_inc;
  logic [PcW-1:0]        c_pc;
  logic [PwW-1:0]        c_pw;

  assign win_after      = req_commit ? d_time_q : window_second_q;
  assign prev_after     = req_commit ? prev_n : previous_count_q;
  assign cur_base_after = req_commit ? cur_n : current_count_q;

  assign c_roll = c_time_q != win_after;
  assign c_adj  = win_after == TimeW'(c_time_q - TimeW'(1));
  assign c_p    = c_roll ? (c_adj ? cur_base_after : '0) : prev_after;
  assign c_inc  = req_commit && c_roll && c_adj && (cur_base_after != '1);

  assign c_pc = PcW'(c_p) * PcW'(c_c_q);
  assign c_pw = PwW'(c_p) * PwW'(c_w_q);

  always_ff @(posedge clk_i) begin
    if (c_mv) begin
      d_mode_q  <= c_mode_q;
      d_time_q  <= c_time_q;
      d_w_q     <= c_w_q;
      d_now_q   <= c_now_q;
      d_c_q     <= c_c_q;
      d_pc_q    <= c_pc;
      d_pwl_q   <= c_pw[ResidW-1:0];
      d_inc_q   <= c_inc;
      d_gprev_q <= req_commit && grant;
    end
  end

  // --------------------------------------------------------------------------
  // Response register. A zero limit grants every request with estimate 0;
  // heartbeat queries always report estimate 0.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (d_mv) begin
      if (d_mode_q == swrl_pkg::MODE_HEARTBEAT) begin
        rsp_granted_q <= hb_due;
        rsp_est_q     <= '0;
      end else if (d_active) begin
        rsp_granted_q <= grant;
        rsp_est_q     <= est;
      end else begin
        rsp_granted_q <= 1'b1;
        rsp_est_q     <= '0;
      end
    end
  end

  assign rsp_o.valid                   = rsp_v_q;
  assign rsp_o.payload.granted         = rsp_granted_q;
  assign rsp_o.payload.window_estimate = rsp_est_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // The window second moves only when an active request commits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_commit |=> $stable(window_second_q))
    else $error("window second changed without a committing request");

  // A granted request records its own time as the last activity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_commit && grant) |=> (last_activity_q == $past(d_now_q)))
    else $error("granted request did not refresh the activity time");

  // The input is held off only when every stage holds a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (a_v_q && b_v_q && c_v_q && d_v_q && rsp_v_q))
    else $error("request refused while the pipeline has a free stage");

endmodule

`default_nettype wire
